[src/pfd_pkg.sv]
// Package for the frame field decoder: parse phases, wire types and sizes.
`timescale 1ns / 1ps

package pfd_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_FIELDS = 6;
	localparam int ACC_W      = 64;
	localparam int SHIFT_W    = 7;
	localparam int FIELD_W    = 3;

	localparam logic [7:0]         OPCODE_RESET = 8'd3;
	localparam logic [SHIFT_W-1:0] SHIFT_STEP   = 7'd7;
	localparam logic [SHIFT_W-1:0] SHIFT_LIMIT  = 7'd64;
	localparam logic [VALUE_W-1:0] SKIP_I32     = 32'd4;
	localparam logic [VALUE_W-1:0] SKIP_I64     = 32'd8;

	// protobuf wire types
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_I32    = 3'd5;

	// field select code: zero means no held field is addressed
	localparam logic [FIELD_W-1:0] FIELD_NONE = 3'd0;
	localparam logic [FIELD_W-1:0] FIELD_BAD  = 3'd7;

	typedef enum logic [5:0] {
		PH_OPCODE = 6'b000001,
		PH_TAG    = 6'b000010,
		PH_VALUE  = 6'b000100,
		PH_LENGTH = 6'b001000,
		PH_SKIP   = 6'b010000,
		PH_ERROR  = 6'b100000
	} phase_t;

	typedef logic [VALUE_W-1:0] value_t;

endpackage

[src/protobuf_frame_field_decoder_core.sv]
// Top level: byte-serial protobuf frame decoder with six held varint fields.
//
//  channel | signals                                   | dir | transaction
//  --------+-------------------------------------------+-----+------------------------------
//  cfg     | cfg_valid, cfg_ready, frame_opcode        | in  | one opcode register write
//  in      | in_valid, in_ready, data_byte, last_byte  | in  | one frame byte
//  out     | out_valid, out_ready, frame_ok, 6 values  | out | one result per last byte
//
// One byte per cycle when not stalled; out_valid is set as the last byte leaves stage 1.
// The rate is set by the combinational varint shift-or and phase update on the stage-1 reg.
// arst_n clears the parse state, held values and opcode (to 3); cfg_ready is always high.
// A last byte waits in stage 1 while the result register is full, which stalls in_ready.
`timescale 1ns / 1ps

module protobuf_frame_field_decoder_core
	import pfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   frame_opcode,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         frame_ok,
	output logic [31:0]  power_value,
	output logic [31:0]  cadence_value,
	output logic [31:0]  speed_hundredths,
	output logic [31:0]  heart_rate,
	output logic [31:0]  extra_one,
	output logic [31:0]  extra_two
);

	logic [7:0] opcode_q;

	// stage 1: accepted byte
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	phase_t             phase_q;
	logic [ACC_W-1:0]   acc_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [FIELD_W-1:0] field_q;
	value_t             skip_q;
	value_t             held_q [NUM_FIELDS];

	// result register
	logic   res_valid_q;
	logic   res_ok_q;
	value_t res_vals_q [NUM_FIELDS];

	logic go_s1;

	// next-state logic
	phase_t             phase_n;
	logic [ACC_W-1:0]   acc_n;
	logic [ACC_W-1:0]   acc_or;
	logic [SHIFT_W-1:0] shift_n;
	logic [SHIFT_W-1:0] shift_inc;
	logic [FIELD_W-1:0] field_n;
	value_t             skip_n;
	logic               held_we;
	value_t             held_wdata;
	logic               ok_n;

	assign cfg_ready = 1'b1;
	assign go_s1     = valid_s1 && (!last_s1 || !res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || go_s1;

	always_comb begin
		phase_n    = phase_q;
		acc_n      = acc_q;
		shift_n    = shift_q;
		field_n    = field_q;
		skip_n     = skip_q;
		held_we    = 1'b0;
		held_wdata = acc_q[VALUE_W-1:0];
		acc_or     = acc_q | (ACC_W'(byte_s1[6:0]) << shift_q[5:0]);
		shift_inc  = shift_q + SHIFT_STEP;

		unique case (phase_q)
			PH_OPCODE: begin
				phase_n = (byte_s1 == opcode_q) ? PH_TAG : PH_ERROR;
			end
			PH_SKIP: begin
				skip_n = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
				if (skip_n == '0) begin
					phase_n = PH_TAG;
				end
			end
			PH_TAG, PH_VALUE, PH_LENGTH: begin
				acc_n = acc_or;
				if (byte_s1[7]) begin
					shift_n = shift_inc;
					if (shift_inc >= SHIFT_LIMIT) begin
						phase_n = PH_ERROR;
					end
				end else begin
					acc_n   = '0;
					shift_n = '0;
					if (phase_q == PH_TAG) begin
						// field numbers outside 1..6 (also huge ones) map to no field
						if (acc_or[ACC_W-1:6] == '0 && acc_or[5:3] != FIELD_NONE
								&& acc_or[5:3] != FIELD_BAD) begin
							field_n = acc_or[5:3];
						end else begin
							field_n = FIELD_NONE;
						end
						case (acc_or[2:0])
							WT_VARINT: phase_n = PH_VALUE;
							WT_LEN:    phase_n = PH_LENGTH;
							WT_I32: begin
								skip_n  = SKIP_I32;
								phase_n = PH_SKIP;
							end
							WT_I64: begin
								skip_n  = SKIP_I64;
								phase_n = PH_SKIP;
							end
							default:   phase_n = PH_ERROR;
						endcase
					end else if (phase_q == PH_VALUE) begin
						held_we    = (field_q != FIELD_NONE);
						held_wdata = acc_or[VALUE_W-1:0];
						phase_n    = PH_TAG;
					end else begin
						if (acc_or[ACC_W-1:VALUE_W] != '0) begin
							phase_n = PH_ERROR;
						end else if (acc_or == '0) begin
							phase_n = PH_TAG;
						end else begin
							skip_n  = acc_or[VALUE_W-1:0];
							phase_n = PH_SKIP;
						end
					end
				end
			end
			PH_ERROR: begin
				phase_n = PH_ERROR;
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		ok_n = (phase_n == PH_TAG) && (shift_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= OPCODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			opcode_q <= frame_opcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			acc_q   <= '0;
			shift_q <= '0;
			field_q <= FIELD_NONE;
			skip_q  <= '0;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				held_q[i] <= '0;
			end
		end else if (go_s1) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				if (held_we && field_q == FIELD_W'(i + 1)) begin
					held_q[i] <= held_wdata;
				end
			end
			if (last_s1) begin
				phase_q <= PH_OPCODE;
				acc_q   <= '0;
				shift_q <= '0;
				field_q <= FIELD_NONE;
				skip_q  <= '0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				shift_q <= shift_n;
				field_q <= field_n;
				skip_q  <= skip_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// snapshot includes a value written by the last byte itself
	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_ok_q <= ok_n;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				res_vals_q[i] <= (held_we && field_q == FIELD_W'(i + 1)) ? held_wdata
					: held_q[i];
			end
		end
	end

	assign out_valid        = res_valid_q;
	assign frame_ok         = res_ok_q;
	assign power_value      = res_vals_q[0];
	assign cadence_value    = res_vals_q[1];
	assign speed_hundredths = res_vals_q[2];
	assign heart_rate       = res_vals_q[3];
	assign extra_one        = res_vals_q[4];
	assign extra_two        = res_vals_q[5];

	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> res_valid_q)
		else $error("last byte processed but no result loaded");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stage 1 byte lost during stall");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skip phase with nothing left to skip");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_ERROR |-> shift_q < SHIFT_LIMIT)
		else $error("varint shift past 64 bits outside error phase");

endmodule
